/* design/tmsc_pkg.sv */
`default_nettype none
package tmsc_pkg;

    localparam int unsigned TCP_PROTOCOL_NUMBER = 6;
    localparam int unsigned DIGEST_BYTE_COUNT   = 16;
    localparam int unsigned IP_HEADER_BYTES     = 20;
    localparam int unsigned TCP_HEADER_BYTES    = 20;
    localparam int unsigned PSEUDO_BYTES        = 12;

    localparam logic [31:0] MD5_INIT_A = 32'h67452301;
    localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
    localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
    localparam logic [31:0] MD5_INIT_D = 32'h10325476;

    // configuration register indexes
    localparam logic [1:0] REG_PACKET_LENGTH  = 2'd0;
    localparam logic [1:0] REG_DIGEST_FIRST   = 2'd1;
    localparam logic [1:0] REG_DIGEST_SECOND  = 2'd2;

    typedef logic [31:0] word_t;

    function automatic word_t md5_k(input logic [5:0] i);
        word_t k;
        unique case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word index used in round i
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0:    g = i[3:0];
            2'd1:    g = 4'((i[3:0] << 2) + i[3:0] + 4'd1);
            2'd2:    g = 4'((i[3:0] << 1) + i[3:0] + 4'd5);
            default: g = 4'((i[3:0] << 3) - i[3:0]);
        endcase
        return g;
    endfunction

    function automatic word_t rotl32(input word_t x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage
`default_nettype wire

/* design/tcp_md5_signature_checker_top.sv */
`default_nettype none
// tcp md5 signature checker
// slave stream: one byte per request; tdata = byte_value, tuser = action
// (0 packet byte, 1 secret byte), tlast marks the final byte of packet or secret.
// master stream: one result per finished secret; tdata[0] = match.
// config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready (always ready);
// index 0 packet_length, 1 expected digest bytes 0..7, 2 expected digest bytes 8..15.
// the ip byte that ends the addresses also absorbs the 12-byte pseudo-header, one byte a
// cycle; each completed 64-byte block is compressed one md5 round a cycle in a single
// shared round unit. the last byte of a secret also absorbs the padding and length, 9 to
// 72 more bytes plus one or two compressions, and then presents the result.
// s_tready is high only while the sequencer is idle.
// reset (aresetn low, synchronous) returns registers to packet_length 40, digest zero,
// and clears the context; block stores are undefined until written.
// if the receiver stalls, the result waits in the output register and the block keeps
// taking bytes; only a second result stalls, until the first is taken.
module tcp_md5_signature_checker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tuser,   // [0] action
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] match, [7:1] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GEN   = 3'd1;   // one absorbed byte a cycle until a block fills
    localparam logic [2:0] ST_PRE   = 3'd2;   // first message word read
    localparam logic [2:0] ST_ROUND = 3'd3;   // 64 rounds
    localparam logic [2:0] ST_ADD   = 3'd4;   // chaining add
    localparam logic [2:0] ST_DONE  = 3'd5;   // result waiting for output slot

    // byte generator modes
    localparam logic [2:0] GM_BYTE   = 3'd0;
    localparam logic [2:0] GM_PSEUDO = 3'd1;
    localparam logic [2:0] GM_PADB   = 3'd2;
    localparam logic [2:0] GM_PADZ   = 3'd3;
    localparam logic [2:0] GM_LEN    = 3'd4;
    localparam logic [2:0] GM_END    = 3'd5;

    logic [2:0]  state_reg;
    logic [2:0]  gm_reg;
    logic [3:0]  gk_reg;
    logic [7:0]  byte_reg;
    logic        pad_reg;
    logic        commit_reg;
    logic        sec_reg;        // current item is a secret byte
    logic        mix_reg;        // first secret block, low bytes come from base bank
    logic [5:0]  split_reg;
    logic        bb_reg;         // base bank select
    logic        secret_active_reg;
    logic [34:0] bits_reg;
    logic        match_reg;

    logic [15:0] packet_length_reg;
    logic [63:0] digest_first_reg;
    logic [63:0] digest_second_reg;

    tmsc_pkg::word_t chain_reg [4];
    tmsc_pkg::word_t base_chain_reg [4];
    logic [31:0] count_reg;
    logic [31:0] base_count_reg;
    logic [15:0] pos_reg;
    logic [3:0]  offset_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;

    tmsc_pkg::word_t a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  round_reg;
    logic [3:0]  gcur_reg;

    // block stores: packet/base banks and the secret bank
    tmsc_pkg::word_t pb_mem [32];
    tmsc_pkg::word_t s_mem [16];
    tmsc_pkg::word_t pb_rd_reg;
    tmsc_pkg::word_t s_rd_reg;

    logic        in_fire;
    logic        absorb_en;
    logic [7:0]  absorb_byte;
    logic [31:0] count_next;
    logic [3:0]  rd_g;
    logic [15:0] seg_len;
    logic [7:0]  pseudo_byte;
    logic [3:0]  off_eff;
    logic [15:0] data_start;
    tmsc_pkg::word_t m_word, f_val, t_val, b_next;
    logic [63:0] hi_val, lo_val;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign m_tdata   = {7'd0, match_reg};
    assign seg_len   = 16'(packet_length_reg - 16'(tmsc_pkg::IP_HEADER_BYTES));
    assign count_next = count_reg + 32'd1;
    assign off_eff   = (offset_reg < 4'd5) ? 4'd5 : offset_reg;
    assign data_start = 16'(tmsc_pkg::IP_HEADER_BYTES) + {10'd0, off_eff, 2'b00};

    always_comb begin
        unique case (gk_reg)
            4'd0:    pseudo_byte = src_reg[31:24];
            4'd1:    pseudo_byte = src_reg[23:16];
            4'd2:    pseudo_byte = src_reg[15:8];
            4'd3:    pseudo_byte = src_reg[7:0];
            4'd4:    pseudo_byte = dst_reg[31:24];
            4'd5:    pseudo_byte = dst_reg[23:16];
            4'd6:    pseudo_byte = dst_reg[15:8];
            4'd7:    pseudo_byte = dst_reg[7:0];
            4'd8:    pseudo_byte = 8'd0;
            4'd9:    pseudo_byte = 8'(tmsc_pkg::TCP_PROTOCOL_NUMBER);
            4'd10:   pseudo_byte = seg_len[15:8];
            default: pseudo_byte = seg_len[7:0];
        endcase
    end

    // byte source of the absorb step
    always_comb begin
        absorb_en   = 1'b0;
        absorb_byte = 8'd0;
        if (state_reg == ST_GEN) begin
            unique case (gm_reg)
                GM_BYTE:   begin absorb_en = 1'b1; absorb_byte = byte_reg; end
                GM_PSEUDO: begin absorb_en = 1'b1; absorb_byte = pseudo_byte; end
                GM_PADB:   begin absorb_en = 1'b1; absorb_byte = 8'h80; end
                GM_PADZ:   begin absorb_en = 1'b1; absorb_byte = 8'h00; end
                GM_LEN:    begin
                    absorb_en   = 1'b1;
                    absorb_byte = 8'({29'd0, bits_reg} >> {gk_reg[2:0], 3'b000});
                end
                default:   absorb_en = 1'b0;
            endcase
        end
    end

    // message word assembly, first secret block mixes base and secret bytes
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (!sec_reg || (mix_reg && ({gcur_reg, 2'(j)} < split_reg)))
                m_word[8*j +: 8] = pb_rd_reg[8*j +: 8];
            else
                m_word[8*j +: 8] = s_rd_reg[8*j +: 8];
        end
    end

    always_comb begin
        unique case (round_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_val  = f_val + a_reg + tmsc_pkg::md5_k(round_reg) + m_word;
        b_next = b_reg + tmsc_pkg::rotl32(t_val, tmsc_pkg::md5_s(round_reg));
    end

    assign rd_g = (state_reg == ST_PRE) ? tmsc_pkg::md5_g(6'd0)
                                        : tmsc_pkg::md5_g(6'(round_reg + 6'd1));

    always_comb begin
        hi_val = '0;
        lo_val = '0;
        for (int i = 0; i < 8; i++) begin
            hi_val[8*(7-i) +: 8] = chain_reg[i/4][8*(i%4) +: 8];
            lo_val[8*(7-i) +: 8] = chain_reg[2 + i/4][8*(i%4) +: 8];
        end
    end

    // block stores
    always_ff @(posedge aclk) begin
        if (absorb_en) begin
            if (sec_reg)
                s_mem[count_reg[5:2]][8*count_reg[1:0] +: 8] <= absorb_byte;
            else
                pb_mem[{~bb_reg, count_reg[5:2]}][8*count_reg[1:0] +: 8] <= absorb_byte;
        end
        pb_rd_reg <= pb_mem[{sec_reg ? bb_reg : ~bb_reg, rd_g}];
        s_rd_reg  <= s_mem[rd_g];
        gcur_reg  <= rd_g;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            gm_reg            <= GM_END;
            gk_reg            <= '0;
            pad_reg           <= 1'b0;
            commit_reg        <= 1'b0;
            sec_reg           <= 1'b0;
            mix_reg           <= 1'b0;
            split_reg         <= '0;
            bb_reg            <= 1'b0;
            secret_active_reg <= 1'b0;
            m_tvalid          <= 1'b0;
            packet_length_reg <= 16'd40;
            digest_first_reg  <= '0;
            digest_second_reg <= '0;
            chain_reg         <= '{tmsc_pkg::MD5_INIT_A, tmsc_pkg::MD5_INIT_B,
                                   tmsc_pkg::MD5_INIT_C, tmsc_pkg::MD5_INIT_D};
            base_chain_reg    <= '{tmsc_pkg::MD5_INIT_A, tmsc_pkg::MD5_INIT_B,
                                   tmsc_pkg::MD5_INIT_C, tmsc_pkg::MD5_INIT_D};
            count_reg         <= '0;
            base_count_reg    <= '0;
            pos_reg           <= '0;
            offset_reg        <= '0;
            src_reg           <= '0;
            dst_reg           <= '0;
            round_reg         <= '0;
        end else begin
            if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;

            if (cfg_valid) begin
                unique case (cfg_index)
                    tmsc_pkg::REG_PACKET_LENGTH: packet_length_reg <= cfg_data[15:0];
                    tmsc_pkg::REG_DIGEST_FIRST:  digest_first_reg  <= cfg_data;
                    tmsc_pkg::REG_DIGEST_SECOND: digest_second_reg <= cfg_data;
                    default: ;
                endcase
            end

            // absorb step: one byte into the block, compression when it fills
            if (absorb_en) begin
                count_reg <= count_next;
                unique case (gm_reg)
                    GM_BYTE: begin
                        bits_reg <= {count_next, 3'b000};
                        gm_reg   <= pad_reg ? GM_PADB : GM_END;
                    end
                    GM_PSEUDO: begin
                        gk_reg <= gk_reg + 4'd1;
                        if (gk_reg == 4'(tmsc_pkg::PSEUDO_BYTES - 1))
                            gm_reg <= GM_END;
                    end
                    GM_PADB, GM_PADZ: begin
                        gk_reg <= '0;
                        gm_reg <= (count_next[5:0] == 6'd56) ? GM_LEN : GM_PADZ;
                    end
                    default: begin
                        gk_reg <= gk_reg + 4'd1;
                        if (gk_reg == 4'd7)
                            gm_reg <= GM_END;
                    end
                endcase
                if (count_next[5:0] == 6'd0)
                    state_reg <= ST_PRE;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        state_reg <= ST_GEN;
                        gk_reg    <= '0;
                        byte_reg  <= s_tdata;
                        pad_reg   <= s_tlast;
                        sec_reg   <= s_tuser;
                        gm_reg    <= GM_END;
                        if (s_tuser) begin
                            // secret byte
                            pos_reg    <= '0;
                            commit_reg <= 1'b0;
                            gm_reg     <= GM_BYTE;
                            if (!secret_active_reg) begin
                                chain_reg <= base_chain_reg;
                                count_reg <= base_count_reg;
                                mix_reg   <= 1'b1;
                                split_reg <= base_count_reg[5:0];
                            end
                            secret_active_reg <= !s_tlast;
                        end else begin
                            // packet byte
                            secret_active_reg <= 1'b0;
                            commit_reg        <= s_tlast;
                            if (pos_reg == 16'd0) begin
                                chain_reg <= '{tmsc_pkg::MD5_INIT_A, tmsc_pkg::MD5_INIT_B,
                                               tmsc_pkg::MD5_INIT_C, tmsc_pkg::MD5_INIT_D};
                                count_reg <= '0;
                            end
                            if (pos_reg >= 16'd12 && pos_reg < 16'd16)
                                src_reg <= {src_reg[23:0], s_tdata};
                            else if (pos_reg >= 16'd16 && pos_reg < 16'd20)
                                dst_reg <= {dst_reg[23:0], s_tdata};
                            if (pos_reg == 16'(tmsc_pkg::IP_HEADER_BYTES - 1)) begin
                                gm_reg <= GM_PSEUDO;
                            end else if (pos_reg >= 16'(tmsc_pkg::IP_HEADER_BYTES) &&
                                         pos_reg < 16'(tmsc_pkg::IP_HEADER_BYTES +
                                                       tmsc_pkg::TCP_HEADER_BYTES)) begin
                                if (pos_reg == 16'd32)
                                    offset_reg <= s_tdata[7:4];
                                // checksum bytes hashed as zero
                                if (pos_reg == 16'd36 || pos_reg == 16'd37)
                                    byte_reg <= 8'd0;
                                gm_reg  <= GM_BYTE;
                                pad_reg <= 1'b0;
                            end else if (pos_reg >= 16'(tmsc_pkg::IP_HEADER_BYTES +
                                                        tmsc_pkg::TCP_HEADER_BYTES)) begin
                                if (pos_reg >= data_start && pos_reg < packet_length_reg) begin
                                    gm_reg  <= GM_BYTE;
                                    pad_reg <= 1'b0;
                                end
                            end
                            if (s_tlast)
                                pos_reg <= '0;
                            else if (pos_reg != 16'hFFFF)
                                pos_reg <= pos_reg + 16'd1;
                        end
                    end
                end
                ST_GEN: begin
                    if (gm_reg == GM_END) begin
                        if (commit_reg) begin
                            base_chain_reg <= chain_reg;
                            base_count_reg <= count_reg;
                            bb_reg         <= ~bb_reg;
                            commit_reg     <= 1'b0;
                        end
                        if (sec_reg && pad_reg)
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_IDLE;
                    end
                end
                ST_PRE: begin
                    a_reg     <= chain_reg[0];
                    b_reg     <= chain_reg[1];
                    c_reg     <= chain_reg[2];
                    d_reg     <= chain_reg[3];
                    round_reg <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    a_reg     <= d_reg;
                    d_reg     <= c_reg;
                    c_reg     <= b_reg;
                    b_reg     <= b_next;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                        state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    if (sec_reg)
                        mix_reg <= 1'b0;
                    state_reg <= ST_GEN;
                end
                ST_DONE: begin
                    // compare only once the output slot is free, the old result stays intact
                    if (!m_tvalid || m_tready) begin
                        match_reg <= (hi_val == digest_first_reg) &&
                                     (lo_val == digest_second_reg);
                        m_tvalid  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // chaining add only after a full set of rounds
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADD |-> $past(state_reg) == ST_ROUND && $past(round_reg) == 6'd63)
        else $error("chaining add without 64 rounds");

    // a result only comes from a secret that ended
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> sec_reg && pad_reg)
        else $error("result from a non-final item");

    // an accepted request keeps the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("second request taken during work");

    // compression starts only on a block boundary
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PRE |-> count_reg[5:0] == 6'd0)
        else $error("compression off block boundary");

endmodule
`default_nettype wire
